// File: rtl/rvx_pkg.sv
// Shared types and constants for the RV64IM execute unit.
// No dependencies; imported by every module of the block.
package rvx_pkg;

    localparam int XLEN = 64;
    localparam int RegAddrW = 5;
    localparam int NumRegs = 32;
    localparam logic [63:0] ResetPc = 64'h0000_0000_8000_0000;
    localparam logic [4:0] A0Index = 5'd10;
    localparam logic [31:0] EbreakWord = 32'h0010_0073;

    localparam logic [6:0] OP_LUI    = 7'h37;
    localparam logic [6:0] OP_AUIPC  = 7'h17;
    localparam logic [6:0] OP_JAL    = 7'h6F;
    localparam logic [6:0] OP_JALR   = 7'h67;
    localparam logic [6:0] OP_BRANCH = 7'h63;
    localparam logic [6:0] OP_LOAD   = 7'h03;
    localparam logic [6:0] OP_STORE  = 7'h23;
    localparam logic [6:0] OP_IMM    = 7'h13;
    localparam logic [6:0] OP_IMMW   = 7'h1B;
    localparam logic [6:0] OP_OP     = 7'h33;
    localparam logic [6:0] OP_OPW    = 7'h3B;
    localparam logic [6:0] OP_SYSTEM = 7'h73;

    localparam logic [6:0] F7_BASE = 7'h00;
    localparam logic [6:0] F7_ALT  = 7'h20;
    localparam logic [6:0] F7_MULDIV = 7'h01;

    typedef enum logic [2:0] {
        KIND_RETIRED  = 3'd0,
        KIND_LOAD     = 3'd1,
        KIND_STORE    = 3'd2,
        KIND_HALT     = 3'd3,
        KIND_INVALID  = 3'd4,
        KIND_REJECTED = 3'd5
    } kind_t;

    typedef enum logic [2:0] {
        MD_MUL  = 3'd0,
        MD_DIV  = 3'd1,
        MD_DIVU = 3'd2,
        MD_REM  = 3'd3,
        MD_REMU = 3'd4
    } md_op_t;

    typedef struct packed {
        logic capture;
        logic md_start;
        logic finish;
    } dp_cmd_t;

    typedef struct packed {
        logic need_md;
        logic md_done;
        logic out_free;
    } dp_status_t;

endpackage

// File: rtl/rvx_in_if.sv
// Input channel of the execute unit: valid/ready plus one item payload.
// No dependencies.
interface rvx_in_if;
    logic        valid;
    logic        ready;
    logic        opcode;
    logic [31:0] instruction;
    logic [63:0] load_data;

    modport source (output valid, output opcode, output instruction, output load_data,
                    input ready);
    modport sink (input valid, input opcode, input instruction, input load_data,
                  output ready);
endinterface

// File: rtl/rvx_out_if.sv
// Result channel of the execute unit: valid/ready plus one result payload.
// No dependencies.
interface rvx_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  result_kind;
    logic [63:0] instruction_pc;
    logic [63:0] next_pc;
    logic [63:0] mem_address;
    logic [1:0]  mem_size_log2;
    logic [63:0] store_data;
    logic [4:0]  dest_index;
    logic [63:0] dest_value;

    modport source (output valid, output result_kind, output instruction_pc,
                    output next_pc, output mem_address, output mem_size_log2,
                    output store_data, output dest_index, output dest_value,
                    input ready);
    modport sink (input valid, input result_kind, input instruction_pc,
                  input next_pc, input mem_address, input mem_size_log2,
                  input store_data, input dest_index, input dest_value,
                  output ready);
endinterface

// File: rtl/rvx_muldiv.sv
// Iterative multiply / divide unit, one bit per cycle, 64 steps.
// Depends on rvx_pkg.
module rvx_muldiv
    import rvx_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  md_op_t      op,
    input  logic [63:0] a,
    input  logic [63:0] b,
    output logic        done,
    output logic [63:0] result
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [63:0] x_reg, x_next;
    logic [63:0] y_reg, y_next;
    logic [63:0] acc_reg, acc_next;
    logic        neg_q_reg, neg_q_next;
    logic        neg_r_reg, neg_r_next;
    logic        bzero_reg, bzero_next;
    md_op_t      op_reg, op_next;

    logic        is_signed;
    logic        a_neg;
    logic        b_neg;
    logic [64:0] trial;

    always_comb
    begin
        is_signed  = (op == MD_DIV) || (op == MD_REM);
        a_neg      = is_signed & a[63];
        b_neg      = is_signed & b[63];
        trial      = {acc_reg, x_reg[63]} - {1'b0, y_reg};
        busy_next  = busy_reg;
        done_next  = done_reg;
        cnt_next   = cnt_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        acc_next   = acc_reg;
        neg_q_next = neg_q_reg;
        neg_r_next = neg_r_reg;
        bzero_next = bzero_reg;
        op_next    = op_reg;
        if (start)
        begin
            busy_next  = 1'b1;
            done_next  = 1'b0;
            cnt_next   = '1;
            acc_next   = '0;
            op_next    = op;
            neg_q_next = a_neg ^ b_neg;
            neg_r_next = a_neg;
            bzero_next = (b == '0);
            if (op == MD_MUL)
            begin
                x_next = a;
                y_next = b;
            end
            else
            begin
                x_next = a_neg ? (64'd0 - a) : a;
                y_next = b_neg ? (64'd0 - b) : b;
            end
        end
        else if (busy_reg)
        begin
            // advance one step; shift-add for multiply, restoring for divide
            if (op_reg == MD_MUL)
            begin
                acc_next = acc_reg + (y_reg[0] ? x_reg : 64'd0);
                x_next   = {x_reg[62:0], 1'b0};
                y_next   = {1'b0, y_reg[63:1]};
            end
            else if (!trial[64])
            begin
                acc_next = trial[63:0];
                x_next   = {x_reg[62:0], 1'b1};
            end
            else
            begin
                acc_next = {acc_reg[62:0], x_reg[63]};
                x_next   = {x_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg     <= x_next;
        y_reg     <= y_next;
        acc_reg   <= acc_next;
        neg_q_reg <= neg_q_next;
        neg_r_reg <= neg_r_next;
        bzero_reg <= bzero_next;
        op_reg    <= op_next;
    end

    always_comb
    begin
        case (op_reg)
            MD_MUL: result = acc_reg;
            MD_DIV, MD_DIVU:
                result = bzero_reg ? '1 : (neg_q_reg ? (64'd0 - x_reg) : x_reg);
            MD_REM, MD_REMU:
                result = neg_r_reg ? (64'd0 - acc_reg) : acc_reg;
            default: result = acc_reg;
        endcase
    end

    assign done = done_reg;

endmodule

// File: rtl/rvx_ctrl.sv
// Sequencing state machine of the execute unit.
// Depends on rvx_pkg; drives rvx_datapath by command and status structs.
module rvx_ctrl
    import rvx_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_DEC  = 4'b0010,
        ST_MD   = 4'b0100,
        ST_FIN  = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        in_ready     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DEC;
                end
            end
            ST_DEC:
            begin
                if (status.need_md)
                begin
                    cmd.md_start = 1'b1;
                    state_next   = ST_MD;
                end
                else
                begin
                    state_next = ST_FIN;
                end
            end
            ST_MD:
            begin
                if (status.md_done)
                    state_next = ST_FIN;
            end
            ST_FIN:
            begin
                // hold until the output register can take the result
                if (status.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// File: rtl/rvx_datapath.sv
// Datapath: register file, decode, ALU, architectural state, output register.
// Depends on rvx_pkg and rvx_muldiv.
module rvx_datapath
    import rvx_pkg::*;
#(
    parameter logic [63:0] RESET_PC = ResetPc
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  dp_cmd_t     cmd,
    output dp_status_t  status,
    input  logic        in_opcode,
    input  logic [31:0] in_instruction,
    input  logic [63:0] in_load_data,
    input  logic        cfg_we,
    input  logic [63:0] cfg_wdata,
    output logic [63:0] reset_pc,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  out_kind,
    output logic [63:0] out_ipc,
    output logic [63:0] out_npc,
    output logic [63:0] out_addr,
    output logic [1:0]  out_size,
    output logic [63:0] out_sdata,
    output logic [4:0]  out_dest,
    output logic [63:0] out_dval
);

    function automatic logic [63:0] sext32(input logic [63:0] x);
        return {{32{x[31]}}, x[31:0]};
    endfunction

    function automatic logic [63:0] size_mask(input logic [1:0] s);
        logic [63:0] m;
        case (s)
            2'd0: m = 64'h0000_0000_0000_00FF;
            2'd1: m = 64'h0000_0000_0000_FFFF;
            2'd2: m = 64'h0000_0000_FFFF_FFFF;
            default: m = '1;
        endcase
        return m;
    endfunction

    logic [63:0]         rf_mem [NumRegs];
    logic [NumRegs-1:0]  rf_valid_reg;
    logic [RegAddrW-1:0] rs1_addr;
    logic [RegAddrW-1:0] rs2_addr;
    logic [63:0]         rs1_reg;
    logic [63:0]         rs2_reg;

    logic        op_reg;
    logic [31:0] insn_reg;
    logic [63:0] ldata_reg;

    logic [63:0] pc_reg, pc_next;
    logic [63:0] reset_pc_reg;
    logic        lp_reg, lp_next;
    logic [4:0]  ld_dest_reg, ld_dest_next;
    logic [1:0]  ld_size_reg, ld_size_next;
    logic        ld_signed_reg, ld_signed_next;
    logic        halted_reg, halted_next;
    logic        out_valid_reg;

    logic [6:0]  opc;
    logic [2:0]  f3;
    logic [6:0]  f7;
    logic [4:0]  rd;
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] imm_i, imm_s, imm_b, imm_j, imm_u;
    logic [63:0] pc4;
    logic [63:0] jalr_sum;
    logic [63:0] ld_masked;
    logic [5:0]  sh6;
    logic [4:0]  sh5;

    logic        reject;
    logic        ok;
    logic        taken;
    logic        is_branch, is_load, is_store, is_md, is_ebreak;
    logic [63:0] v;
    logic [63:0] npc;
    logic [63:0] m_addr;
    logic [1:0]  m_size;
    logic [63:0] m_sdata;

    kind_t       r_kind;
    logic [63:0] r_ipc, r_npc, r_addr, r_sdata, r_dval;
    logic [1:0]  r_size;
    logic [4:0]  r_dest;
    logic        rf_we;

    md_op_t      md_op;
    logic [63:0] md_a, md_b;
    logic        md_done;
    logic [63:0] md_result;

    // register file: read both ports at capture, x0 and unwritten entries read zero
    assign rs1_addr = (in_instruction == EbreakWord) ? A0Index : in_instruction[19:15];
    assign rs2_addr = in_instruction[24:20];

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            rs1_reg   <= rf_valid_reg[rs1_addr] ? rf_mem[rs1_addr] : 64'd0;
            rs2_reg   <= rf_valid_reg[rs2_addr] ? rf_mem[rs2_addr] : 64'd0;
            op_reg    <= in_opcode;
            insn_reg  <= in_instruction;
            ldata_reg <= in_load_data;
        end
        if (rf_we)
            rf_mem[r_dest] <= r_dval;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rf_valid_reg <= '0;
        else if (rf_we)
            rf_valid_reg[r_dest] <= 1'b1;
    end

    // decode
    always_comb
    begin
        opc   = insn_reg[6:0];
        f3    = insn_reg[14:12];
        f7    = insn_reg[31:25];
        rd    = insn_reg[11:7];
        a     = rs1_reg;
        b     = rs2_reg;
        imm_i = {{52{insn_reg[31]}}, insn_reg[31:20]};
        imm_s = {{52{insn_reg[31]}}, insn_reg[31:25], insn_reg[11:7]};
        imm_b = {{51{insn_reg[31]}}, insn_reg[31], insn_reg[7], insn_reg[30:25],
                 insn_reg[11:8], 1'b0};
        imm_j = {{43{insn_reg[31]}}, insn_reg[31], insn_reg[19:12], insn_reg[20],
                 insn_reg[30:21], 1'b0};
        imm_u = {{32{insn_reg[31]}}, insn_reg[31:12], 12'd0};
        pc4   = pc_reg + 64'd4;
        jalr_sum = a + imm_i;
        reject = halted_reg || (!op_reg && lp_reg) || (op_reg && !lp_reg);

        is_md = ((opc == OP_OP) || (opc == OP_OPW)) && (f7 == F7_MULDIV) &&
                ((f3 == 3'd0) || (f3 >= 3'd4));
        case (f3)
            3'd0: md_op = MD_MUL;
            3'd4: md_op = MD_DIV;
            3'd5: md_op = MD_DIVU;
            3'd6: md_op = MD_REM;
            default: md_op = MD_REMU;
        endcase
        if (opc == OP_OPW && (md_op == MD_DIV || md_op == MD_REM))
        begin
            md_a = sext32(a);
            md_b = sext32(b);
        end
        else if (opc == OP_OPW && (md_op == MD_DIVU || md_op == MD_REMU))
        begin
            md_a = {32'd0, a[31:0]};
            md_b = {32'd0, b[31:0]};
        end
        else
        begin
            md_a = a;
            md_b = b;
        end
    end

    rvx_muldiv u_muldiv (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cmd.md_start),
        .op     (md_op),
        .a      (md_a),
        .b      (md_b),
        .done   (md_done),
        .result (md_result)
    );

    // execute
    always_comb
    begin
        ok        = 1'b1;
        taken     = 1'b0;
        is_branch = 1'b0;
        is_load   = 1'b0;
        is_store  = 1'b0;
        is_ebreak = 1'b0;
        v         = '0;
        npc       = pc4;
        m_addr    = a + imm_i;
        m_size    = f3[1:0];
        m_sdata   = '0;
        sh6       = insn_reg[25:20];
        sh5       = insn_reg[24:20];
        case (opc)
            OP_LUI:   v = imm_u;
            OP_AUIPC: v = pc_reg + imm_u;
            OP_JAL:
            begin
                v   = pc4;
                npc = pc_reg + imm_j;
            end
            OP_JALR:
            begin
                ok  = (f3 == 3'd0);
                v   = pc4;
                npc = {jalr_sum[63:1], 1'b0};
            end
            OP_BRANCH:
            begin
                is_branch = 1'b1;
                case (f3)
                    3'd0: taken = (a == b);
                    3'd1: taken = (a != b);
                    3'd4: taken = ($signed(a) < $signed(b));
                    3'd5: taken = !($signed(a) < $signed(b));
                    3'd6: taken = (a < b);
                    3'd7: taken = (a >= b);
                    default: ok = 1'b0;
                endcase
                if (taken)
                    npc = pc_reg + imm_b;
            end
            OP_LOAD:
            begin
                ok      = (f3 != 3'd7);
                is_load = 1'b1;
            end
            OP_STORE:
            begin
                ok       = (f3 <= 3'd3);
                is_store = 1'b1;
                m_addr   = a + imm_s;
                m_sdata  = b & size_mask(f3[1:0]);
            end
            OP_IMM:
            begin
                case (f3)
                    3'd0: v = a + imm_i;
                    3'd2: v = {63'd0, $signed(a) < $signed(imm_i)};
                    3'd3: v = {63'd0, a < imm_i};
                    3'd4: v = a ^ imm_i;
                    3'd6: v = a | imm_i;
                    3'd7: v = a & imm_i;
                    3'd1:
                    begin
                        ok = (insn_reg[31:26] == 6'd0);
                        v  = a << sh6;
                    end
                    default:
                    begin
                        if (insn_reg[31:26] == 6'd0)
                            v = a >> sh6;
                        else if (insn_reg[31:26] == 6'h10)
                            v = $unsigned($signed(a) >>> sh6);
                        else
                            ok = 1'b0;
                    end
                endcase
            end
            OP_IMMW:
            begin
                if (f3 == 3'd0)
                    v = sext32(a + imm_i);
                else if (f3 == 3'd1 && f7 == F7_BASE)
                    v = sext32({32'd0, a[31:0] << sh5});
                else if (f3 == 3'd5 && f7 == F7_BASE)
                    v = sext32({32'd0, a[31:0] >> sh5});
                else if (f3 == 3'd5 && f7 == F7_ALT)
                    v = sext32($unsigned($signed(sext32(a)) >>> sh5));
                else
                    ok = 1'b0;
            end
            OP_OP:
            begin
                if (f7 == F7_BASE)
                begin
                    case (f3)
                        3'd0: v = a + b;
                        3'd1: v = a << b[5:0];
                        3'd2: v = {63'd0, $signed(a) < $signed(b)};
                        3'd3: v = {63'd0, a < b};
                        3'd4: v = a ^ b;
                        3'd5: v = a >> b[5:0];
                        3'd6: v = a | b;
                        default: v = a & b;
                    endcase
                end
                else if (f7 == F7_ALT && f3 == 3'd0)
                    v = a - b;
                else if (f7 == F7_ALT && f3 == 3'd5)
                    v = $unsigned($signed(a) >>> b[5:0]);
                else if (is_md)
                    v = md_result;
                else
                    ok = 1'b0;
            end
            OP_OPW:
            begin
                if (f7 == F7_BASE && f3 == 3'd0)
                    v = sext32(a + b);
                else if (f7 == F7_BASE && f3 == 3'd1)
                    v = sext32({32'd0, a[31:0] << b[4:0]});
                else if (f7 == F7_BASE && f3 == 3'd5)
                    v = sext32({32'd0, a[31:0] >> b[4:0]});
                else if (f7 == F7_ALT && f3 == 3'd0)
                    v = sext32(a - b);
                else if (f7 == F7_ALT && f3 == 3'd5)
                    v = sext32($unsigned($signed(sext32(a)) >>> b[4:0]));
                else if (is_md)
                    v = sext32(md_result);
                else
                    ok = 1'b0;
            end
            OP_SYSTEM:
            begin
                is_ebreak = (insn_reg == EbreakWord);
                ok        = is_ebreak;
            end
            default: ok = 1'b0;
        endcase
    end

    // outcome and state update
    always_comb
    begin
        r_kind   = KIND_RETIRED;
        r_ipc    = pc_reg;
        r_npc    = pc_reg;
        r_addr   = '0;
        r_size   = '0;
        r_sdata  = '0;
        r_dest   = '0;
        r_dval   = '0;
        rf_we    = 1'b0;
        pc_next  = pc_reg;
        lp_next  = lp_reg;
        ld_dest_next   = ld_dest_reg;
        ld_size_next   = ld_size_reg;
        ld_signed_next = ld_signed_reg;
        halted_next    = halted_reg;
        ld_masked = ldata_reg & size_mask(ld_size_reg);
        if (reject)
        begin
            r_kind = KIND_REJECTED;
        end
        else if (op_reg)
        begin
            lp_next = 1'b0;
            r_ipc   = pc_reg - 64'd4;
            r_dest  = ld_dest_reg;
            if (ld_signed_reg)
            begin
                case (ld_size_reg)
                    2'd0: r_dval = {{56{ld_masked[7]}}, ld_masked[7:0]};
                    2'd1: r_dval = {{48{ld_masked[15]}}, ld_masked[15:0]};
                    2'd2: r_dval = {{32{ld_masked[31]}}, ld_masked[31:0]};
                    default: r_dval = ld_masked;
                endcase
            end
            else
            begin
                r_dval = ld_masked;
            end
            if (ld_dest_reg == 5'd0)
                r_dval = '0;
            rf_we = (ld_dest_reg != 5'd0);
        end
        else if (!ok)
        begin
            r_kind      = KIND_INVALID;
            halted_next = 1'b1;
        end
        else if (is_ebreak)
        begin
            r_kind      = KIND_HALT;
            r_dval      = a;
            halted_next = 1'b1;
        end
        else if (is_load)
        begin
            r_kind         = KIND_LOAD;
            r_npc          = npc;
            r_addr         = m_addr;
            r_size         = m_size;
            r_dest         = rd;
            pc_next        = npc;
            lp_next        = 1'b1;
            ld_dest_next   = rd;
            ld_size_next   = f3[1:0];
            ld_signed_next = (f3 < 3'd4);
        end
        else if (is_store)
        begin
            r_kind  = KIND_STORE;
            r_npc   = npc;
            r_addr  = m_addr;
            r_size  = m_size;
            r_sdata = m_sdata;
            pc_next = npc;
        end
        else if (is_branch)
        begin
            r_npc   = npc;
            pc_next = npc;
        end
        else
        begin
            r_npc   = npc;
            pc_next = npc;
            r_dest  = rd;
            r_dval  = (rd == 5'd0) ? 64'd0 : v;
            rf_we   = (rd != 5'd0);
        end
        rf_we = rf_we & cmd.finish;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= RESET_PC;
            reset_pc_reg  <= RESET_PC;
            lp_reg        <= 1'b0;
            ld_dest_reg   <= '0;
            ld_size_reg   <= '0;
            ld_signed_reg <= 1'b0;
            halted_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                reset_pc_reg <= cfg_wdata;
                pc_reg       <= cfg_wdata;
            end
            else if (cmd.finish)
            begin
                pc_reg <= pc_next;
            end
            if (cmd.finish)
            begin
                lp_reg        <= lp_next;
                ld_dest_reg   <= ld_dest_next;
                ld_size_reg   <= ld_size_next;
                ld_signed_reg <= ld_signed_next;
                halted_reg    <= halted_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            out_kind  <= r_kind;
            out_ipc   <= r_ipc;
            out_npc   <= r_npc;
            out_addr  <= r_addr;
            out_size  <= r_size;
            out_sdata <= r_sdata;
            out_dest  <= r_dest;
            out_dval  <= r_dval;
        end
    end

    assign out_valid       = out_valid_reg;
    assign reset_pc        = reset_pc_reg;
    assign status.need_md  = !reject && !op_reg && is_md;
    assign status.md_done  = md_done;
    assign status.out_free = !out_valid_reg || out_ready;

`ifndef SYNTH
    a_x0_never_written: assert property (@(posedge clk) disable iff (!rst_n)
        !rf_valid_reg[0])
        else $error("register x0 marked written");
    a_finish_shows_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> out_valid_reg)
        else $error("finished result not presented");
    a_no_write_when_halted: assert property (@(posedge clk) disable iff (!rst_n)
        halted_reg |-> !rf_we)
        else $error("register write while halted");
`endif

endmodule

// File: rtl/rv64im_instruction_execute_unit.sv
// Top level of the RV64IM execute unit.
// Depends on rvx_pkg, rvx_in_if, rvx_out_if, rvx_ctrl and rvx_datapath.
//
// Usage:
//   req carries one beat per item: opcode 0 executes the instruction word at
//   the current program counter, opcode 1 returns the data of a pending load.
//   rsp carries exactly one result beat per accepted item.
//   The APB port holds reset_pc at byte address 0; writing it also loads the
//   program counter. Write it only while the unit is idle. pready is tied high.
// Sequencing:
//   One item at a time. Accept edge: capture and register read; then the
//   decode state; then the finish state, which loads the output register
//   once it is free. mul, div and rem run on a bit-serial unit in a state
//   of their own between decode and finish. The output register lets the
//   next beat in while a result waits.
// Reset:
//   rst_n clears all registers to zero (per-entry valid bits, no clear pass),
//   loads the program counter and reset_pc from the RESET_PC parameter (default
//   0x8000_0000) and clears the load-pending and halted flags.
// Stall:
//   If rsp.ready stays low, the result holds; the next item's result waits in
//   the finish state until the output register drains.
module rv64im_instruction_execute_unit
    import rvx_pkg::*;
#(
    parameter logic [63:0] RESET_PC = ResetPc
)
(
    input  logic        clk,
    input  logic        rst_n,
    rvx_in_if.sink      req,
    rvx_out_if.source   rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    dp_cmd_t     cmd;
    dp_status_t  status;
    logic        cfg_we;
    logic [63:0] reset_pc;

    // register 0 only; anything at the next slot is dropped
    assign cfg_we = psel && penable && pwrite && (paddr[3] == 1'b0);
    assign prdata = (paddr[3] == 1'b0) ? reset_pc : 64'd0;
    assign pready = 1'b1;

    rvx_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .status   (status),
        .cmd      (cmd)
    );

    rvx_datapath #(
        .RESET_PC (RESET_PC)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .in_opcode      (req.opcode),
        .in_instruction (req.instruction),
        .in_load_data   (req.load_data),
        .cfg_we         (cfg_we),
        .cfg_wdata      (pwdata),
        .reset_pc       (reset_pc),
        .out_valid      (rsp.valid),
        .out_ready      (rsp.ready),
        .out_kind       (rsp.result_kind),
        .out_ipc        (rsp.instruction_pc),
        .out_npc        (rsp.next_pc),
        .out_addr       (rsp.mem_address),
        .out_size       (rsp.mem_size_log2),
        .out_sdata      (rsp.store_data),
        .out_dest       (rsp.dest_index),
        .out_dval       (rsp.dest_value)
    );

endmodule
